@@ src/regex_pattern_tokenizer_unit_defines.svh @@
// assertion macros for the checking module rpt_back
`ifndef REGEX_PATTERN_TOKENIZER_UNIT_DEFINES_SVH
`define REGEX_PATTERN_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define RPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is held
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/rpt_pkg.sv @@
package rpt_pkg;

    // widths of the stream payloads
    localparam int S_DATA_WIDTH    = 8;
    localparam int M_USER_WIDTH    = 3;
    localparam int QUANT_WIDTH     = 16;
    localparam int CLASS_BITS      = 256;
    localparam int TOKEN_BITS      = 8 + 2 * QUANT_WIDTH + 1 + CLASS_BITS;
    localparam int M_DATA_WIDTH    = ((TOKEN_BITS + 7) / 8) * 8;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FIFO_DEPTH      = 4;

    // pattern bytes with a meaning of their own
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        TOK_CHAR   = 3'd0,
        TOK_STAR   = 3'd1,
        TOK_PIPE   = 3'd2,
        TOK_LPAREN = 3'd3,
        TOK_RPAREN = 3'd4,
        TOK_CONCAT = 3'd5,
        TOK_CLASS  = 3'd6,
        TOK_QUANT  = 3'd7
    } tok_type_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CSTART = 3'd1,
        MODE_CS0    = 3'd2,
        MODE_CS1    = 3'd3,
        MODE_CS2    = 3'd4,
        MODE_QWS    = 3'd5,
        MODE_QV1    = 3'd6,
        MODE_QV2    = 3'd7
    } lex_mode_t;

    // one queued record: an optional concat followed by the main token
    typedef struct packed {
        logic                   concat;
        tok_type_t              tok_type;
        logic [7:0]             tok_char;
        logic [QUANT_WIDTH-1:0] quant_min;
        logic [QUANT_WIDTH-1:0] quant_max;
        logic                   quant_max_valid;
        logic [CLASS_BITS-1:0]  class_bits;
    } token_rec_t;

    // handshake between lexer and queue
    typedef struct packed {
        logic push;
        logic full;
    } q_ctrl_t;

endpackage

@@ src/rpt_front.sv @@
module rpt_front
    import rpt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_DATA_WIDTH-1:0] s_tdata,   // [7:0] ch
    input  logic                    s_tlast,   // last
    input  logic                    q_full,
    output q_ctrl_t                 q_ctrl,
    output token_rec_t              rec
);

    lex_mode_t               mode_reg, mode_next;
    logic [CLASS_BITS-1:0]   bitmap_reg, bitmap_next;
    logic                    negate_reg, negate_next;
    logic [7:0]              pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0]  low_reg, low_next;
    logic [COUNT_WIDTH-1:0]  high_reg, high_next;
    logic                    prior_char_reg, prior_char_next;
    logic                    emit;
    logic                    fire;

    // decimal digit append with saturation at the counter maximum
    function automatic logic [COUNT_WIDTH-1:0] count_digit(
        input logic [COUNT_WIDTH-1:0] v,
        input logic [7:0]             c
    );
        logic [COUNT_WIDTH+3:0] r;
        r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{COUNT_WIDTH{1'b0}}, c[3:0]};
        if (r[COUNT_WIDTH+3:COUNT_WIDTH] != 4'b0) begin
            count_digit = '1;
        end else begin
            count_digit = r[COUNT_WIDTH-1:0];
        end
    endfunction

    // count widened or cut to the result field width
    function automatic logic [QUANT_WIDTH-1:0] to_quant(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+QUANT_WIDTH-1:0] t;
        t = {{QUANT_WIDTH{1'b0}}, v};
        to_quant = t[QUANT_WIDTH-1:0];
    endfunction

    function automatic logic [CLASS_BITS-1:0] one_bit(input logic [7:0] b);
        one_bit = {{(CLASS_BITS-1){1'b0}}, 1'b1} << b;
    endfunction

    assign fire          = s_tvalid && s_tready;
    assign s_tready      = !q_full;
    assign q_ctrl.full   = q_full;
    assign q_ctrl.push   = fire && emit;

    // lexer next state and token record
    always_comb begin
        logic [7:0]            c;
        logic                  class_done;
        logic [7:0]            lo;
        logic [7:0]            hi;
        logic [CLASS_BITS-1:0] range_mask;
        c               = s_tdata[7:0];
        class_done      = 1'b0;
        lo              = (pend_reg < c) ? pend_reg : c;
        hi              = (pend_reg < c) ? c : pend_reg;
        mode_next       = mode_reg;
        bitmap_next     = bitmap_reg;
        negate_next     = negate_reg;
        pend_next       = pend_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        prior_char_next = prior_char_reg;
        emit            = 1'b0;
        rec             = '0;
        rec.tok_type    = TOK_CHAR;

        // parallel compare for a range fill, inclusive of both ends
        for (int i = 0; i < CLASS_BITS; i++) begin
            range_mask[i] = (8'(i) >= lo) && (8'(i) <= hi);
        end

        unique case (mode_reg)
            MODE_NORMAL: begin
                priority if (c == CH_STAR) begin
                    emit = 1'b1;
                    rec.tok_type = TOK_STAR;
                end else if (c == CH_PIPE) begin
                    emit = 1'b1;
                    rec.tok_type = TOK_PIPE;
                end else if (c == CH_LPAREN) begin
                    emit = 1'b1;
                    rec.tok_type = TOK_LPAREN;
                end else if (c == CH_RPAREN) begin
                    emit = 1'b1;
                    rec.tok_type = TOK_RPAREN;
                    rec.tok_char = c;
                end else if (c == CH_LBRACK) begin
                    bitmap_next = '0;
                    negate_next = 1'b0;
                    pend_next   = '0;
                    mode_next   = MODE_CSTART;
                end else if (c == CH_LBRACE) begin
                    low_next  = '0;
                    high_next = '0;
                    mode_next = MODE_QWS;
                end else begin
                    emit         = 1'b1;
                    rec.concat   = prior_char_reg;
                    rec.tok_type = TOK_CHAR;
                    rec.tok_char = c;
                end
            end
            MODE_CSTART, MODE_CS0: begin
                priority if (mode_reg == MODE_CSTART && c == CH_CARET) begin
                    negate_next = 1'b1;
                    mode_next   = MODE_CS0;
                end else if (c == CH_DASH) begin
                    bitmap_next = bitmap_reg | one_bit(CH_DASH);
                    mode_next   = MODE_CS0;
                end else if (c == CH_RBRACK) begin
                    class_done = 1'b1;
                end else begin
                    pend_next = c;
                    mode_next = MODE_CS1;
                end
            end
            MODE_CS1: begin
                priority if (c == CH_DASH) begin
                    mode_next = MODE_CS2;
                end else if (c == CH_RBRACK) begin
                    bitmap_next = bitmap_reg | one_bit(pend_reg);
                    class_done  = 1'b1;
                end else begin
                    bitmap_next = bitmap_reg | one_bit(pend_reg);
                    pend_next   = c;
                end
            end
            MODE_CS2: begin
                if (c == CH_RBRACK) begin
                    bitmap_next = bitmap_reg | one_bit(pend_reg) | one_bit(CH_DASH);
                    class_done  = 1'b1;
                end else begin
                    bitmap_next = bitmap_reg | range_mask;
                    mode_next   = MODE_CS0;
                end
            end
            MODE_QWS, MODE_QV1: begin
                priority if (mode_reg == MODE_QWS && (c == CH_SPACE || c == CH_TAB)) begin
                    mode_next = mode_reg;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    low_next  = count_digit(low_reg, c);
                    mode_next = MODE_QV1;
                end else if (c == CH_COMMA) begin
                    mode_next = MODE_QV2;
                end else if (c == CH_RBRACE) begin
                    emit          = 1'b1;
                    rec.tok_type  = TOK_QUANT;
                    rec.quant_min = to_quant(low_reg);
                    mode_next     = MODE_NORMAL;
                end else begin
                    // malformed quantifier: byte dropped
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_QV2: begin
                priority if (c >= CH_ZERO && c <= CH_NINE) begin
                    high_next = count_digit(high_reg, c);
                end else if (c == CH_RBRACE) begin
                    emit                = 1'b1;
                    rec.tok_type        = TOK_QUANT;
                    rec.quant_min       = to_quant(low_reg);
                    rec.quant_max       = to_quant(high_reg);
                    rec.quant_max_valid = 1'b1;
                    mode_next           = MODE_NORMAL;
                end else begin
                    mode_next = MODE_NORMAL;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
            end
        endcase

        // pattern ending inside a class flushes it
        if (s_tlast && (mode_next == MODE_CSTART || mode_next == MODE_CS0 ||
                        mode_next == MODE_CS1 || mode_next == MODE_CS2)) begin
            class_done = 1'b1;
        end

        if (class_done) begin
            emit           = 1'b1;
            rec.tok_type   = TOK_CLASS;
            rec.class_bits = negate_next ? ~bitmap_next : bitmap_next;
            bitmap_next    = '0;
            negate_next    = 1'b0;
            pend_next      = '0;
            mode_next      = MODE_NORMAL;
        end

        // char tokens arm the concat, every other token disarms it
        if (emit) begin
            prior_char_next = (rec.tok_type == TOK_CHAR);
        end

        // end of pattern returns everything to reset values
        if (s_tlast) begin
            mode_next       = MODE_NORMAL;
            bitmap_next     = '0;
            negate_next     = 1'b0;
            pend_next       = '0;
            low_next        = '0;
            high_next       = '0;
            prior_char_next = 1'b0;
        end
    end

    // lexer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            bitmap_reg     <= '0;
            negate_reg     <= 1'b0;
            pend_reg       <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            prior_char_reg <= 1'b0;
        end else if (fire) begin
            mode_reg       <= mode_next;
            bitmap_reg     <= bitmap_next;
            negate_reg     <= negate_next;
            pend_reg       <= pend_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            prior_char_reg <= prior_char_next;
        end
    end

endmodule

@@ src/rpt_queue.sv @@
module rpt_queue
    import rpt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_ctrl_t    q_ctrl,
    input  token_rec_t wr_rec,
    output logic       q_full,
    input  logic       pop,
    output logic       rd_valid,
    output token_rec_t rd_rec
);

    localparam int PTR_WIDTH = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    token_rec_t           mem_reg [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_full   = (count_reg == CNT_WIDTH'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign do_push  = q_ctrl.push && !q_ctrl.full;
    assign do_pop   = pop && rd_valid;

    // pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

@@ src/rpt_back.sv @@
`include "regex_pattern_tokenizer_unit_defines.svh"

module rpt_back
    import rpt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_valid,
    input  token_rec_t              rd_rec,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_WIDTH-1:0] m_tdata,  // tok_char, quant_min, quant_max,
                                              // quant_max_valid, class_word0..3, pad
    output logic [M_USER_WIDTH-1:0] m_tuser,  // tok_type
    output logic                    m_tlast   // run_end
);

    logic                    valid_reg, valid_next;
    logic                    pend_main_reg, pend_main_next;
    token_rec_t              hold_reg, hold_next;
    tok_type_t               type_reg, type_next;
    logic [M_DATA_WIDTH-1:0] data_reg, data_next;
    logic                    last_reg, last_next;
    logic                    load_ok;

    function automatic logic [M_DATA_WIDTH-1:0] pack_main(input token_rec_t r);
        pack_main = {{(M_DATA_WIDTH-TOKEN_BITS){1'b0}}, r.class_bits, r.quant_max_valid,
                     r.quant_max, r.quant_min, r.tok_char};
    endfunction

    assign load_ok  = !valid_reg || m_tready;
    assign pop      = load_ok && !pend_main_reg && rd_valid;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = type_reg;
    assign m_tlast  = last_reg;

    // expand a record into a concat beat and a main beat, or into a main beat alone when it has no concat
    always_comb begin
        valid_next     = valid_reg;
        pend_main_next = pend_main_reg;
        hold_next      = hold_reg;
        type_next      = type_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        if (load_ok) begin
            priority if (pend_main_reg) begin
                valid_next     = 1'b1;
                pend_main_next = 1'b0;
                type_next      = hold_reg.tok_type;
                data_next      = pack_main(hold_reg);
                last_next      = 1'b1;
            end else if (rd_valid && rd_rec.concat) begin
                valid_next     = 1'b1;
                pend_main_next = 1'b1;
                hold_next      = rd_rec;
                type_next      = TOK_CONCAT;
                data_next      = '0;
                last_next      = 1'b0;
            end else if (rd_valid) begin
                valid_next = 1'b1;
                type_next  = rd_rec.tok_type;
                data_next  = pack_main(rd_rec);
                last_next  = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            pend_main_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            pend_main_reg <= pend_main_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        type_reg <= type_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    // only a concat beat is ever shown without run end
    `RPT_ASSERT_IMPLY(a_concat_only_mid, aclk, aresetn, valid_reg && !last_reg, type_reg == TOK_CONCAT)
    // a held main token always sits behind a shown concat beat
    `RPT_ASSERT_IMPLY(a_pend_has_beat, aclk, aresetn, pend_main_reg, valid_reg && !last_reg)
    // the main token follows its concat directly
    `RPT_ASSERT_NEXT(a_main_follows, aclk, aresetn, valid_reg && m_tready && !last_reg, valid_reg && last_reg)
    // no new record is taken while a main token is still held
    `RPT_ASSERT_IMPLY(a_no_pop_held, aclk, aresetn, pend_main_reg, !pop)

endmodule

@@ src/regex_pattern_tokenizer_unit.sv @@
// path: a token is written into the queue, then loaded into the output register, before it appears on the m_ side
// throughput: one pattern byte per cycle while the queue is not full; a char after a char yields a concat
//   and a char token, two output beats, so the single output register sets the pace there
// reset: synchronous, active-low aresetn clears lexer state, queue and output valid
// a four-record queue lets the lexer run ahead of a stalled output
module regex_pattern_tokenizer_unit
    import rpt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_DATA_WIDTH-1:0] s_tdata,   // [7:0] ch
    input  logic                    s_tlast,   // last
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_WIDTH-1:0] m_tdata,   // [7:0] tok_char, [23:8] quant_min,
                                               // [39:24] quant_max, [40] quant_max_valid,
                                               // [104:41] class_word0, [168:105] class_word1,
                                               // [232:169] class_word2, [296:233] class_word3
    output logic [M_USER_WIDTH-1:0] m_tuser,   // [2:0] tok_type
    output logic                    m_tlast    // run_end
);

    q_ctrl_t    q_ctrl;
    token_rec_t wr_rec;
    token_rec_t rd_rec;
    logic       q_full;
    logic       rd_valid;
    logic       pop;

    // lexer front end
    rpt_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_ctrl   (q_ctrl),
        .rec      (wr_rec)
    );

    // token record queue
    rpt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_ctrl   (q_ctrl),
        .wr_rec   (wr_rec),
        .q_full   (q_full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_rec   (rd_rec)
    );

    // token output stage
    rpt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_rec   (rd_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
